// ----- rtl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fixed-point ALU
// Holds the command codes, the fixed-point format and the divider cell record.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 14;
  localparam int WORD_W    = 32;
  localparam int DIV_W     = WORD_W + FRAC_BITS;  // dividend / quotient width
  localparam int CMD_W     = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INT_TO_FIX = 4'd0;
  localparam logic [CMD_W-1:0] CMD_TRUNC      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ROUND      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ADD        = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SUB        = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ADD_INT    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SUB_INT    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_MUL        = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MUL_INT    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DIV        = 4'd9;
  localparam logic [CMD_W-1:0] CMD_DIV_INT    = 4'd10;

  // Record handed from one divider cell to the next
  typedef struct packed {
    logic              valid;
    logic              div;    // result comes from the quotient
    logic              neg;    // quotient is negated at the end
    logic              dz;     // zero divisor seen
    logic [WORD_W-1:0] side;   // result of every non-divide command
    logic [WORD_W-1:0] den;    // divisor magnitude
    logic [WORD_W-1:0] rem;    // partial remainder
    logic [DIV_W-1:0]  dq;     // dividend bits out the top, quotient bits in
  } cell_t;

endpackage

// ----- rtl/fixed_point_17_14_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu: Q17.14 fixed-point ALU
// Eleven operations on two 32-bit operands, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: tdata carries command, operand_a, operand_b.
//   Output channel m_*: tdata carries result and divide_by_zero.
//   Every item gives exactly one result item, in order.
//   The input stage with the multiplier is loaded at the accepting edge;
//   from there the item passes one operand stage, one division cell per
//   quotient bit, and the output register to the result. All commands take
//   the same path.
//   Throughput: one item per cycle when not stalled; the division is a row
//   of cells, each retiring one quotient bit, so a new item enters every cycle.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops; it rises again once the result is taken.
//   Reset clears all valid bits; no result is pending afterwards.
//   A zero divisor gives result 0 with divide_by_zero set; unused command
//   codes give 0.
// ----------------------------------------------------------------------------
module fixed_point_17_14_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result[31:0], divide_by_zero[32]
);
  import fpa_pkg::*;

  localparam int NCELL = DIV_W;

  logic                     en;
  // input stage
  logic                     v0;
  logic [CMD_W-1:0]         cmd0;
  logic signed [WORD_W-1:0] a0, b0;
  logic signed [2*WORD_W-1:0] prod0;
  // operand stage logic
  cell_t                    st_next;
  cell_t                    chain [0:NCELL];
  logic [WORD_W-1:0]        a_mag, b_mag;
  logic signed [WORD_W+1:0] rnd;
  logic signed [WORD_W+1:0] rnd_adj;
  logic signed [WORD_W+1:0] tr_adj;
  logic signed [2*WORD_W-1:0] mul_adj;
  // output stage
  logic [DIV_W-1:0]         q_fix;
  logic [WORD_W-1:0]        res_next;
  logic [WORD_W-1:0]        res;
  logic                     dz;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  // Register the operands and the product
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      cmd0  <= s_tdata[3:0];
      a0    <= s_tdata[35:4];
      b0    <= s_tdata[67:36];
      prod0 <= $signed(s_tdata[35:4]) * $signed(s_tdata[67:36]);
    end
  end

  // Form the direct results and the divider operands
  always_comb begin
    a_mag   = a0[WORD_W-1] ? WORD_W'(-a0) : WORD_W'(a0);
    b_mag   = b0[WORD_W-1] ? WORD_W'(-b0) : WORD_W'(b0);
    tr_adj  = (WORD_W+2)'(a0) + (a0[WORD_W-1] ? (WORD_W+2)'((1 << FRAC_BITS) - 1)
                                              : (WORD_W+2)'(0));
    if (a0 > 0) begin
      rnd = (WORD_W+2)'(a0) + (WORD_W+2)'(1 << (FRAC_BITS - 1));
    end else begin
      rnd = (WORD_W+2)'(a0) - (WORD_W+2)'(1 << (FRAC_BITS - 1));
    end
    rnd_adj = rnd + (rnd[WORD_W+1] ? (WORD_W+2)'((1 << FRAC_BITS) - 1)
                                   : (WORD_W+2)'(0));
    mul_adj = prod0 + (prod0[2*WORD_W-1] ? (2*WORD_W)'((1 << FRAC_BITS) - 1)
                                         : (2*WORD_W)'(0));
    st_next       = '0;
    st_next.valid = v0;
    st_next.den   = b_mag;
    st_next.neg   = a0[WORD_W-1] ^ b0[WORD_W-1];
    unique case (cmd0)
      CMD_INT_TO_FIX: st_next.side = WORD_W'(b0 <<< FRAC_BITS);
      CMD_TRUNC:      st_next.side = WORD_W'(tr_adj >>> FRAC_BITS);
      CMD_ROUND:      st_next.side = WORD_W'(rnd_adj >>> FRAC_BITS);
      CMD_ADD:        st_next.side = WORD_W'(a0 + b0);
      CMD_SUB:        st_next.side = WORD_W'(a0 - b0);
      CMD_ADD_INT:    st_next.side = WORD_W'(a0 + (b0 <<< FRAC_BITS));
      CMD_SUB_INT:    st_next.side = WORD_W'(a0 - (b0 <<< FRAC_BITS));
      CMD_MUL:        st_next.side = WORD_W'(mul_adj >>> FRAC_BITS);
      CMD_MUL_INT:    st_next.side = prod0[WORD_W-1:0];
      CMD_DIV: begin
        st_next.dz  = (b0 == '0);
        st_next.div = (b0 != '0);
        st_next.dq  = {a_mag, {FRAC_BITS{1'b0}}};
      end
      CMD_DIV_INT: begin
        st_next.dz  = (b0 == '0);
        st_next.div = (b0 != '0);
        st_next.dq  = {{FRAC_BITS{1'b0}}, a_mag};
      end
      default:        st_next.side = '0;
    endcase
  end

  // Operand stage feeds the cell row
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= st_next.valid;
    end
    if (en) begin
      chain[0].div  <= st_next.div;
      chain[0].neg  <= st_next.neg;
      chain[0].dz   <= st_next.dz;
      chain[0].side <= st_next.side;
      chain[0].den  <= st_next.den;
      chain[0].rem  <= st_next.rem;
      chain[0].dq   <= st_next.dq;
    end
  end

  // Row of division cells, one quotient bit each
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fpa_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Apply the quotient sign and pick the result
  always_comb begin
    q_fix = chain[NCELL].neg ? DIV_W'(-chain[NCELL].dq) : chain[NCELL].dq;
    if (chain[NCELL].div) begin
      res_next = q_fix[WORD_W-1:0];
    end else begin
      res_next = chain[NCELL].side;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain[NCELL].valid;
    end
    if (en) begin
      res <= res_next;
      dz  <= chain[NCELL].dz;
    end
  end

  assign m_tdata = {7'd0, dz, res};

  // Checks
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && dz |-> res == '0)
    else $error("zero divisor result not zero");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(res) && $stable(dz))
    else $error("result changed while stalled");

endmodule

// ----- rtl/fpa_cell.sv -----
// ----------------------------------------------------------------------------
// fpa_cell: one restoring-division cell
// Retires one quotient bit and passes the record on to the next cell.
// ----------------------------------------------------------------------------
module fpa_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  fpa_pkg::cell_t din,
  output fpa_pkg::cell_t dout
);
  import fpa_pkg::*;

  logic [WORD_W+1:0] trial;
  logic [WORD_W-1:0] rem_next;
  logic              qbit;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {1'b0, din.rem, din.dq[DIV_W-1]} - {2'b00, din.den};
    qbit  = ~trial[WORD_W+1];
    if (qbit) begin
      rem_next = trial[WORD_W-1:0];
    end else begin
      rem_next = {din.rem[WORD_W-2:0], din.dq[DIV_W-1]};
    end
  end

  // Advance the record
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.div  <= din.div;
      dout.neg  <= din.neg;
      dout.dz   <= din.dz;
      dout.side <= din.side;
      dout.den  <= din.den;
      dout.rem  <= rem_next;
      dout.dq   <= {din.dq[DIV_W-2:0], qbit};
    end
  end

endmodule

// ----- verif/fixed_point_17_14_alu_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu_tb: self-checking bench for the Q17.14 ALU
// Drives a directed table, then random bursts of commands, and checks every
// result item in order against its typed value or a bit-exact predictor.
// ----------------------------------------------------------------------------
module fixed_point_17_14_alu_tb;
  import fpa_pkg::*;

  localparam int N_RANDOM   = 2000;
  localparam int WATCHDOG   = 20000;
  localparam int LATENCY    = DIV_W + 3;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              dz;
  } alu_out_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              known;   // expected value typed in below
    logic [WORD_W-1:0] value;
    logic              dz;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  alu_out_t pending_results[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       stimulus_done = 1'b0;
  bit       long_holdoff = 1'b0;

  fixed_point_17_14_alu dut (.*);

  always #2 clk = ~clk;

  // Compute the ALU output for one item
  function automatic alu_out_t alu_predict(logic [CMD_W-1:0] cmd,
                                           logic [WORD_W-1:0] ua,
                                           logic [WORD_W-1:0] ub);
    longint   a;
    longint   b;
    longint   scale;
    longint   half;
    alu_out_t r;
    a = longint'($signed(ua));
    b = longint'($signed(ub));
    scale = longint'(1) << FRAC_BITS;
    half = scale / 2;
    r = '0;
    case (cmd)
      CMD_INT_TO_FIX: r.value = ub << FRAC_BITS;
      CMD_TRUNC:      r.value = WORD_W'(a / scale);
      CMD_ROUND:      r.value = (a > 0) ? WORD_W'((a + half) / scale)
                                        : WORD_W'((a - half) / scale);
      CMD_ADD:        r.value = ua + ub;
      CMD_SUB:        r.value = ua - ub;
      CMD_ADD_INT:    r.value = ua + (ub << FRAC_BITS);
      CMD_SUB_INT:    r.value = ua - (ub << FRAC_BITS);
      CMD_MUL:        r.value = WORD_W'((a * b) / scale);
      CMD_MUL_INT:    r.value = ua * ub;
      CMD_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else r.value = WORD_W'((a * scale) / b);
      end
      CMD_DIV_INT: begin
        if (b == 0) r.dz = 1'b1;
        else r.value = WORD_W'(a / b);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Directed table: extremes, every command, zero divisor, unused codes
  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] ONES = 32'hffff_ffff;
  vector_t directed[] = '{
    '{CMD_INT_TO_FIX, 32'd0, 32'd1,  1'b1, 32'h0000_4000, 1'b0},
    '{CMD_INT_TO_FIX, 32'd0, MAXP,   1'b0, 32'd0, 1'b0},
    '{CMD_TRUNC,      32'h0000_6000, 32'd0, 1'b1, 32'd1, 1'b0},
    '{CMD_TRUNC,      MINN, ONES,    1'b0, 32'd0, 1'b0},
    '{CMD_ROUND,      32'h0000_2000, 32'd0, 1'b1, 32'd1, 1'b0},
    '{CMD_ROUND,      32'hffff_e000, 32'd0, 1'b1, ONES,  1'b0},
    '{CMD_ROUND,      MAXP, 32'd0,   1'b0, 32'd0, 1'b0},
    '{CMD_ROUND,      MINN, 32'd0,   1'b0, 32'd0, 1'b0},
    '{CMD_ADD,        MAXP, 32'd1,   1'b1, MINN,  1'b0},
    '{CMD_SUB,        MINN, 32'd1,   1'b1, MAXP,  1'b0},
    '{CMD_ADD_INT,    ONES, MAXP,    1'b0, 32'd0, 1'b0},
    '{CMD_SUB_INT,    MINN, MINN,    1'b0, 32'd0, 1'b0},
    '{CMD_MUL,        MAXP, MAXP,    1'b0, 32'd0, 1'b0},
    '{CMD_MUL,        MINN, MINN,    1'b0, 32'd0, 1'b0},
    '{CMD_MUL_INT,    MINN, ONES,    1'b1, MINN,  1'b0},
    '{CMD_DIV,        MAXP, 32'd0,   1'b1, 32'd0, 1'b1},
    '{CMD_DIV,        MINN, ONES,    1'b0, 32'd0, 1'b0},
    '{CMD_DIV,        32'd1, MAXP,   1'b0, 32'd0, 1'b0},
    '{CMD_DIV_INT,    MINN, 32'd0,   1'b1, 32'd0, 1'b1},
    '{CMD_DIV_INT,    MINN, ONES,    1'b1, MINN,  1'b0},
    '{CMD_DIV_INT,    32'hffff_fff9, 32'd2, 1'b1, 32'hffff_fffd, 1'b0},
    '{4'd11,          ONES, ONES,    1'b1, 32'd0, 1'b0},
    '{4'd15,          ONES, 32'd0,   1'b1, 32'd0, 1'b0}
  };

  // Pick an operand that leans toward edges and small values
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0: return MAXP - $urandom_range(0, 2);
      1: return MINN + $urandom_range(0, 2);
      2: return 32'($signed($urandom_range(0, 16)) - 8);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and hold until accepted
  task automatic offer_item(logic [CMD_W-1:0] cmd, logic [31:0] a, logic [31:0] b,
                            logic known, alu_out_t typed);
    alu_out_t expected;
    expected = alu_predict(cmd, a, b);
    if (known && expected != typed)
      $display("table row disagrees with predictor: cmd %0d a %h b %h", cmd, a, b);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, b, a, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(known ? typed : expected);
  endtask

  // Insert a random gap after a burst
  task automatic sender_gap();
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    int burst;
    alu_out_t typed;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      typed.value = directed[i].value;
      typed.dz = directed[i].dz;
      offer_item(directed[i].cmd, directed[i].a, directed[i].b, directed[i].known, typed);
    end
    // Pause until the pipeline has drained
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    burst = $urandom_range(1, 20);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) long_holdoff = 1'b1;
      offer_item(($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(11, 15))
                                              : CMD_W'($urandom_range(0, 10)),
                 random_operand(),
                 ($urandom_range(0, 15) == 0) ? 32'd0 : random_operand(),
                 1'b0, '0);
      if (--burst == 0) begin
        sender_gap();
        burst = $urandom_range(1, 40);
      end
    end
    s_tvalid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: stall pattern, with one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (long_holdoff) begin
        long_holdoff = 1'b0;
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      phase++;
      if ((phase / 500) % 2 == 1) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
    end
  end

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    alu_out_t got;
    alu_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.value = m_tdata[31:0];
      got.dz = m_tdata[32];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h dz %b, got value %h dz %b",
                     want.value, want.dz, got.value, got.dz);
        end
      end
    end
  end

  // Watchdog on handshake activity: stop the run when nothing moves
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("fixed_point_17_14_alu verification failed");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (stimulus_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("fixed_point_17_14_alu verification clean");
    end else begin
      $display("fixed_point_17_14_alu verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fixed_point_17_14_alu.sv
verif/fixed_point_17_14_alu_tb.sv
